// ----- rtl/gnms_pkg.sv -----
// shared constants, types and the angle sector function for the non-maximum suppression block
// no dependencies; compiled first

package gnms_pkg;

  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int MAG_BITS_DEFAULT  = 16;
  localparam int MAX_HEIGHT        = 1024;
  localparam int ANGLE_BITS        = 16;
  localparam int ROW_BITS          = 11;

  // configuration port
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [CFG_DATA_BITS-1:0]  FRAME_HEIGHT_RESET = 11'd480;

  // angle codes in radians times 8192
  localparam int PI_CODE = 25736;
  localparam int EDGE_A  = 3217;   // 22.5 degrees
  localparam int EDGE_B  = 9651;   // 67.5 degrees
  localparam int EDGE_C  = 16085;  // 112.5 degrees
  localparam int EDGE_D  = 22519;  // 157.5 degrees

  localparam int SECTOR_BITS = 2;
  typedef logic [SECTOR_BITS-1:0] sector_t;
  localparam sector_t SEC_VERTICAL   = 2'd0;  // above and below
  localparam sector_t SEC_BACKSLASH  = 2'd1;  // up-left and down-right
  localparam sector_t SEC_HORIZONTAL = 2'd2;  // left and right
  localparam sector_t SEC_SLASH      = 2'd3;  // up-right and down-left

  // which neighbours of a centre pixel lie inside the frame, and whether it is the frame's last pixel
  typedef struct packed {
    logic up;
    logic down;
    logic lft;
    logic rgt;
    logic frame_end;
  } nbr_ok_t;

  function automatic sector_t sector_of(input logic signed [ANGLE_BITS-1:0] angle);
    logic signed [ANGLE_BITS+1:0] a;
    a = (ANGLE_BITS+2)'(angle);
    if (angle < 0) a = a + (ANGLE_BITS+2)'(PI_CODE);
    if (a <= (ANGLE_BITS+2)'(EDGE_A) || a > (ANGLE_BITS+2)'(EDGE_D)) begin
      sector_of = SEC_VERTICAL;
    end else if (a <= (ANGLE_BITS+2)'(EDGE_B)) begin
      sector_of = SEC_BACKSLASH;
    end else if (a <= (ANGLE_BITS+2)'(EDGE_C)) begin
      sector_of = SEC_HORIZONTAL;
    end else begin
      sector_of = SEC_SLASH;
    end
  endfunction

endpackage

// ----- rtl/gnms_pix_if.sv -----
// pixel input channel: valid/ready handshake with action, magnitude and angle
// depends on gnms_pkg

interface gnms_pix_if #(
  parameter int MAG_BITS = gnms_pkg::MAG_BITS_DEFAULT
) ();
  import gnms_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [MAG_BITS-1:0]          pixel_magnitude;
  logic signed [ANGLE_BITS-1:0] pixel_angle;

  modport source (output valid, action, pixel_magnitude, pixel_angle, input ready);
  modport sink (input valid, action, pixel_magnitude, pixel_angle, output ready);
endinterface

// ----- rtl/gnms_res_if.sv -----
// result output channel: valid/ready handshake with suppressed magnitude and frame end flag
// depends on gnms_pkg

interface gnms_res_if #(
  parameter int MAG_BITS = gnms_pkg::MAG_BITS_DEFAULT
) ();
  logic                valid;
  logic                ready;
  logic [MAG_BITS-1:0] out_magnitude;
  logic                frame_end;

  modport source (output valid, out_magnitude, frame_end, input ready);
  modport sink (input valid, out_magnitude, frame_end, output ready);
endinterface

// ----- rtl/gradient_non_maximum_suppression.sv -----
// canny non-maximum suppression over a raster-order stream of gradient pixels
// depends on gnms_pkg, gnms_pix_if and gnms_res_if
//
// usage
//   pix carries one word per pixel (action 0) or one flush word (action 1);
//   res carries one word per centre pixel: its magnitude, or zero where a
//   neighbour along the gradient axis is strictly larger, and frame_end on
//   the last pixel of the frame. configuration is written on cfg_write with
//   cfg_index 0 for frame_width and 1 for frame_height; the user must write
//   it only while idle, the block does not enforce this; a write restarts the frame.
// throughput and latency
//   one pixel per clock while res is not stalled, bound by the line memory: one
//   read and one write per cycle, with the write of the previous word forwarded
//   to the read. a result belongs to the pixel one row and one column back and
//   passes the window shift, the judge stage and the output register. after the
//   last pixel, frame_width + 1 flush words drain the remaining results.
// reset and stalls
//   rst (synchronous) clears the counters and the pipeline; the line memory
//   is not cleared, its unwritten rows are never used. while res is stalled
//   words are still taken until a result waits behind the output register,
//   then pix.ready falls until res.ready returns.

module gradient_non_maximum_suppression #(
  parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAG_BITS  = gnms_pkg::MAG_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gnms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gnms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  gnms_pix_if.sink                            pix,
  gnms_res_if.source                          res
);
  import gnms_pkg::*;

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ENTRY_BITS = MAG_BITS + SECTOR_BITS;
  localparam int WORD_BITS  = 2 * ENTRY_BITS;

  // one stored pixel: sector above magnitude
  typedef logic [ENTRY_BITS-1:0] entry_t;

  // ---------------------------------------------------------------------
  // configuration registers and their clamped working values
  // ---------------------------------------------------------------------
  logic [CFG_DATA_BITS-1:0] frame_width;
  logic [CFG_DATA_BITS-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [COL_BITS-1:0] last_col;  // width - 1, width clamped to [2, MAX_WIDTH]
  logic [ROW_BITS-1:0] height;    // clamped to [2, MAX_HEIGHT]

  always_comb begin
    if (frame_width < CFG_DATA_BITS'(2)) begin
      last_col = COL_BITS'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      last_col = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_BITS'(frame_width - 1'b1);
    end
    if (frame_height < CFG_DATA_BITS'(2)) begin
      height = ROW_BITS'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height = ROW_BITS'(MAX_HEIGHT);
    end else begin
      height = ROW_BITS'(frame_height);
    end
  end

  // ---------------------------------------------------------------------
  // entry stage: input position, result position flags, memory read
  // ---------------------------------------------------------------------
  logic [COL_BITS-1:0] in_column;
  logic [ROW_BITS-1:0] in_row;

  logic                advance;     // whole pipeline moves this cycle
  logic                draining;    // past the last pixel row
  logic                ignore;      // flush with nothing to drain
  logic                take;        // accepted word enters the pipeline
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  logic [COL_BITS-1:0] col_next;
  logic [ROW_BITS-1:0] row_next;
  logic                emit;
  nbr_ok_t             flags;
  entry_t              fresh;

  // a result waiting in the last stage blocks only if the output register is held
  assign pix.ready = advance;

  always_comb begin
    draining = in_row >= height;
    ignore   = pix.action && !draining;
    take     = pix.valid && advance && !ignore;

    // a pixel arriving after the frame starts a new frame at the origin
    if (!pix.action && draining) begin
      col = '0;
      row = '0;
    end else begin
      col = in_column;
      row = in_row;
    end

    fresh = pix.action ? '0 : {sector_of(pix.pixel_angle), pix.pixel_magnitude};

    // first column completes the previous row's last pixel, two rows back;
    // other columns complete the pixel one row up and one column left
    if (col == '0) begin
      emit            = row >= ROW_BITS'(2);
      flags.up        = row >= ROW_BITS'(3);
      flags.down      = row <= height;
      flags.lft       = 1'b1;
      flags.rgt       = 1'b0;
      flags.frame_end = row == ROW_BITS'(height + 1'b1);
    end else begin
      emit            = row >= ROW_BITS'(1) && row <= height;
      flags.up        = row >= ROW_BITS'(2);
      flags.down      = row < height;
      flags.lft       = col >= COL_BITS'(2);
      flags.rgt       = 1'b1;
      flags.frame_end = 1'b0;
    end

    if (flags.frame_end) begin
      col_next = '0;
      row_next = '0;
    end else if (col == last_col) begin
      col_next = '0;
      row_next = row + 1'b1;
    end else begin
      col_next = col + 1'b1;
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (take) begin
      in_column <= col_next;
      in_row    <= row_next;
    end
  end

  // ---------------------------------------------------------------------
  // line memory: one word per column, older row above newer row
  // ---------------------------------------------------------------------
  logic [WORD_BITS-1:0] line_mem [MAX_WIDTH];
  logic [WORD_BITS-1:0] mem_q;
  logic [WORD_BITS-1:0] wr_word;

  logic                 s1_valid;
  logic [COL_BITS-1:0]  s1_col;
  entry_t               s1_fresh;
  logic                 s1_emit;
  nbr_ok_t              s1_flags;
  logic                 byp_hit;
  logic [WORD_BITS-1:0] byp_word;

  always_ff @(posedge clk) begin
    if (take) begin
      mem_q <= line_mem[col];
    end
    if (s1_valid && advance) begin
      line_mem[s1_col] <= wr_word;
    end
  end

  // ---------------------------------------------------------------------
  // read-modify-write stage and window shift
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else if (advance) begin
      s1_valid <= take;
      // same column written on the edge it is read: use the write data
      byp_hit  <= s1_valid && (s1_col == col);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col   <= col;
      s1_fresh <= fresh;
      s1_emit  <= emit;
      s1_flags <= flags;
      byp_word <= wr_word;
    end
  end

  logic [WORD_BITS-1:0] rd_word;
  entry_t               rd_older;
  entry_t               rd_newer;

  always_comb begin
    rd_word  = byp_hit ? byp_word : mem_q;
    rd_older = rd_word[WORD_BITS-1:ENTRY_BITS];
    rd_newer = rd_word[ENTRY_BITS-1:0];
    wr_word  = {rd_newer, s1_fresh};
  end

  // 3x3 window, rows top to bottom, columns left to right
  entry_t win [3][3];

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_older;
      win[1][2] <= rd_newer;
      win[2][2] <= s1_fresh;
    end
  end

  // ---------------------------------------------------------------------
  // judge stage: centre is always the middle of the shifted window
  // ---------------------------------------------------------------------
  logic    s2_emit;
  nbr_ok_t s2_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_emit <= 1'b0;
    end else if (advance) begin
      s2_emit <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_flags <= s1_flags;
    end
  end

  logic [MAG_BITS-1:0] mag;
  sector_t             sec;
  entry_t              nbr_a;
  entry_t              nbr_b;
  logic                ok_a;
  logic                ok_b;
  logic                suppress;

  always_comb begin
    mag = win[1][1][MAG_BITS-1:0];
    sec = win[1][1][ENTRY_BITS-1:MAG_BITS];
    case (sec)
      SEC_VERTICAL: begin
        nbr_a = win[0][1];
        ok_a  = s2_flags.up;
        nbr_b = win[2][1];
        ok_b  = s2_flags.down;
      end
      SEC_BACKSLASH: begin
        nbr_a = win[0][0];
        ok_a  = s2_flags.up && s2_flags.lft;
        nbr_b = win[2][2];
        ok_b  = s2_flags.down && s2_flags.rgt;
      end
      SEC_HORIZONTAL: begin
        nbr_a = win[1][0];
        ok_a  = s2_flags.lft;
        nbr_b = win[1][2];
        ok_b  = s2_flags.rgt;
      end
      SEC_SLASH: begin
        nbr_a = win[0][2];
        ok_a  = s2_flags.up && s2_flags.rgt;
        nbr_b = win[2][0];
        ok_b  = s2_flags.down && s2_flags.lft;
      end
      default: begin
        nbr_a = '0;
        ok_a  = 1'b0;
        nbr_b = '0;
        ok_b  = 1'b0;
      end
    endcase
    // ties keep the centre
    suppress = (ok_a && (mag < nbr_a[MAG_BITS-1:0]))
            || (ok_b && (mag < nbr_b[MAG_BITS-1:0]));
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  logic load;

  assign advance = !s2_emit || !res.valid || res.ready;
  assign load    = s2_emit && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.out_magnitude <= suppress ? '0 : mag;
      res.frame_end     <= s2_flags.frame_end;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_column_in_frame: assert property (@(posedge clk) disable iff (rst)
    in_column <= last_col)
    else $error("input column beyond the frame width");

  a_frame_end_restarts: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_flags.frame_end |-> in_row == '0 && in_column == '0)
    else $error("position counters not restarted after the last result");

  a_frame_end_corner: assert property (@(posedge clk) disable iff (rst)
    s2_emit && s2_flags.frame_end |-> !s2_flags.rgt && !s2_flags.down)
    else $error("frame end flagged away from the bottom right corner");

endmodule
